// ===== design/cpl_pkg.sv =====
`timescale 1ns / 1ps
package cpl_pkg;

  localparam int NUM_KNOTS = 5;
  localparam int POS_STEPS = 400;
  localparam int FRAC_BITS = 8;

  localparam int KNOT_REGS  = 5;
  localparam int KNOTS_USED = (NUM_KNOTS < 2) ? 2 :
                              ((NUM_KNOTS > KNOT_REGS) ? KNOT_REGS : NUM_KNOTS);
  localparam int DEGEN_KNOT = (KNOTS_USED > 2) ? 2 : KNOTS_USED - 1;

  localparam int DATA_W   = 32;
  localparam int BUS_W    = 64;
  localparam int ADDR_W   = 6;
  localparam int KNOT_W   = 34;
  localparam int KPOS_W   = 10;
  localparam int CHAN_W   = 8;
  localparam int KIDX_W   = $clog2(KNOT_REGS);
  localparam int OFF_W    = 33;
  localparam int MULT_W   = $clog2(POS_STEPS + 1);
  localparam int NUM_W    = OFF_W + MULT_W + FRAC_BITS;
  localparam int POS_W    = $clog2((POS_STEPS << FRAC_BITS) + 1);
  localparam int SPAN_W   = 32;
  localparam int REM_W    = (NUM_W > SPAN_W + POS_W) ? NUM_W : SPAN_W + POS_W;
  localparam int SEG_W    = KPOS_W + FRAC_BITS;
  localparam int T_W      = ((POS_W > SEG_W) ? POS_W : SEG_W) + 1;
  localparam int CNUM_W   = SEG_W + CHAN_W + 1;

  localparam logic [2:0] REG_RANGE_LOW  = 3'd0;
  localparam logic [2:0] REG_RANGE_HIGH = 3'd1;
  localparam logic [2:0] REG_KNOT_ZERO  = 3'd2;
  localparam logic [2:0] REG_KNOT_ONE   = 3'd3;
  localparam logic [2:0] REG_KNOT_TWO   = 3'd4;
  localparam logic [2:0] REG_KNOT_THREE = 3'd5;
  localparam logic [2:0] REG_KNOT_FOUR  = 3'd6;

  localparam logic [DATA_W-1:0] RANGE_LOW_RESET  = 32'd0;
  localparam logic [DATA_W-1:0] RANGE_HIGH_RESET = 32'd65536;
  localparam logic [KNOT_REGS-1:0][KNOT_W-1:0] KNOT_RESET = {
    34'd6727598080, 34'd2533359360, 34'd1342225861, 34'd335566288, 34'd16777215
  };

  typedef struct packed {
    logic [DATA_W-1:0]                 range_low;
    logic [DATA_W-1:0]                 range_high;
    logic [KNOT_REGS-1:0][KNOT_W-1:0]  knot;
  } cfg_t;

  typedef struct packed {
    logic clamped;
    logic degen;
  } tag_t;

endpackage

// ===== design/cpl_regs.sv =====
`timescale 1ns / 1ps
module cpl_regs (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpl_pkg::ADDR_W-1:0]  paddr,
  input  logic [cpl_pkg::BUS_W-1:0]   pwdata,
  output logic [cpl_pkg::BUS_W-1:0]   prdata,
  output cpl_pkg::cfg_t               cfg
);

  logic [2:0] idx;
  logic       wr;

  assign idx = paddr[5:3];
  assign wr  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.range_low  <= cpl_pkg::RANGE_LOW_RESET;
      cfg.range_high <= cpl_pkg::RANGE_HIGH_RESET;
      cfg.knot       <= cpl_pkg::KNOT_RESET;
    end else if (wr) begin
      case (idx)
        cpl_pkg::REG_RANGE_LOW:  cfg.range_low  <= pwdata[cpl_pkg::DATA_W-1:0];
        cpl_pkg::REG_RANGE_HIGH: cfg.range_high <= pwdata[cpl_pkg::DATA_W-1:0];
        cpl_pkg::REG_KNOT_ZERO:  cfg.knot[0]    <= pwdata[cpl_pkg::KNOT_W-1:0];
        cpl_pkg::REG_KNOT_ONE:   cfg.knot[1]    <= pwdata[cpl_pkg::KNOT_W-1:0];
        cpl_pkg::REG_KNOT_TWO:   cfg.knot[2]    <= pwdata[cpl_pkg::KNOT_W-1:0];
        cpl_pkg::REG_KNOT_THREE: cfg.knot[3]    <= pwdata[cpl_pkg::KNOT_W-1:0];
        cpl_pkg::REG_KNOT_FOUR:  cfg.knot[4]    <= pwdata[cpl_pkg::KNOT_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      cpl_pkg::REG_RANGE_LOW:  prdata = cpl_pkg::BUS_W'(cfg.range_low);
      cpl_pkg::REG_RANGE_HIGH: prdata = cpl_pkg::BUS_W'(cfg.range_high);
      cpl_pkg::REG_KNOT_ZERO:  prdata = cpl_pkg::BUS_W'(cfg.knot[0]);
      cpl_pkg::REG_KNOT_ONE:   prdata = cpl_pkg::BUS_W'(cfg.knot[1]);
      cpl_pkg::REG_KNOT_TWO:   prdata = cpl_pkg::BUS_W'(cfg.knot[2]);
      cpl_pkg::REG_KNOT_THREE: prdata = cpl_pkg::BUS_W'(cfg.knot[3]);
      cpl_pkg::REG_KNOT_FOUR:  prdata = cpl_pkg::BUS_W'(cfg.knot[4]);
      default:                 prdata = '0;
    endcase
  end

endmodule

// ===== design/cpl_pos_div.sv =====
`timescale 1ns / 1ps
module cpl_pos_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [cpl_pkg::NUM_W-1:0]   num,
  input  cpl_pkg::tag_t               tag_in,
  input  logic [cpl_pkg::SPAN_W-1:0]  divisor,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [cpl_pkg::POS_W-1:0]   pos,
  output cpl_pkg::tag_t               tag_out
);

  localparam int N = cpl_pkg::POS_W;

  logic [N-1:0]                      v;
  logic [N-1:0]                      rdy;
  logic [N-1:0][cpl_pkg::REM_W-1:0]  rem;
  logic [N-1:0][cpl_pkg::POS_W-1:0]  quo;
  cpl_pkg::tag_t [N-1:0]             tag;

  // one quotient bit per stage, most significant first
  for (genvar i = 0; i < N; i++) begin : g_stage
    logic [cpl_pkg::REM_W-1:0] src_rem;
    logic [cpl_pkg::POS_W-1:0] src_quo;
    cpl_pkg::tag_t             src_tag;
    logic                      src_v;
    logic [cpl_pkg::REM_W-1:0] sh;
    logic                      take;

    if (i == 0) begin : g_first
      assign src_rem = cpl_pkg::REM_W'(num);
      assign src_quo = '0;
      assign src_tag = tag_in;
      assign src_v   = in_valid;
    end else begin : g_rest
      assign src_rem = rem[i-1];
      assign src_quo = quo[i-1];
      assign src_tag = tag[i-1];
      assign src_v   = v[i-1];
    end

    if (i == N - 1) begin : g_last
      assign rdy[i] = ~v[i] | ~out_stall;
    end else begin : g_mid
      assign rdy[i] = ~v[i] | rdy[i+1];
    end

    assign sh   = cpl_pkg::REM_W'(divisor) << (N - 1 - i);
    assign take = (src_rem >= sh);

    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= src_v;
      end
    end

    always_ff @(posedge clk) begin
      if (rdy[i]) begin
        rem[i] <= take ? src_rem - sh : src_rem;
        quo[i] <= src_quo | (cpl_pkg::POS_W'(take) << (N - 1 - i));
        tag[i] <= src_tag;
      end
    end
  end

  assign in_stall  = ~rdy[0];
  assign out_valid = v[N-1];
  assign pos       = quo[N-1];
  assign tag_out   = tag[N-1];

endmodule

// ===== design/cpl_interp.sv =====
`timescale 1ns / 1ps
module cpl_interp (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic [cpl_pkg::POS_W-1:0]  pos,
  input  cpl_pkg::tag_t              tag_in,
  input  cpl_pkg::cfg_t              cfg,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic [7:0]                 red,
  output logic [7:0]                 green,
  output logic [7:0]                 blue,
  output logic                       clamped
);

  localparam int ND = cpl_pkg::CHAN_W;
  localparam int N  = 2 + ND;

  logic [N-1:0] v;
  logic [N-1:0] rdy;
  logic [N-1:0] clp;

  for (genvar i = 0; i < N; i++) begin : g_rdy
    logic src_v;

    if (i == 0) begin : g_first
      assign src_v = in_valid;
    end else begin : g_rest
      assign src_v = v[i-1];
    end

    if (i == N - 1) begin : g_last
      assign rdy[i] = ~v[i] | ~out_stall;
    end else begin : g_mid
      assign rdy[i] = ~v[i] | rdy[i+1];
    end
    always_ff @(posedge clk) begin
      if (rst) begin
        v[i] <= 1'b0;
      end else if (rdy[i]) begin
        v[i] <= src_v;
      end
    end
  end

  // stage 0: segment select, endpoints and offset
  logic [cpl_pkg::KIDX_W-1:0]             seg;
  logic [cpl_pkg::KIDX_W-1:0]             seg1;
  logic [cpl_pkg::KPOS_W-1:0]             x0, x1;
  logic signed [cpl_pkg::T_W-1:0]         tt;
  logic signed [cpl_pkg::T_W-1:0]         dd;
  logic [2:0][7:0]                        a_next, b_next;
  logic [cpl_pkg::SEG_W-1:0]              d_next, t_next;

  always_comb begin
    seg = '0;
    for (int k = 0; k <= cpl_pkg::KNOTS_USED - 2; k++) begin
      if ((cpl_pkg::T_W'(cfg.knot[k][33:24]) << cpl_pkg::FRAC_BITS) <= cpl_pkg::T_W'(pos)) begin
        seg = cpl_pkg::KIDX_W'(k);
      end
    end
    seg1 = seg + cpl_pkg::KIDX_W'(1);
    x0   = cfg.knot[seg][33:24];
    x1   = cfg.knot[seg1][33:24];
    dd   = (cpl_pkg::T_W'(x1) - cpl_pkg::T_W'(x0)) <<< cpl_pkg::FRAC_BITS;
    tt   = cpl_pkg::T_W'(pos) - (cpl_pkg::T_W'(x0) <<< cpl_pkg::FRAC_BITS);
    if (tt < 0) begin
      tt = '0;
    end
    if (tt > dd) begin
      tt = dd;
    end
    a_next = cfg.knot[seg][23:0];
    b_next = cfg.knot[seg1][23:0];
    d_next = dd[cpl_pkg::SEG_W-1:0];
    t_next = tt[cpl_pkg::SEG_W-1:0];
    // fixed color: width one, offset zero gives the color back unchanged
    if (tag_in.degen) begin
      a_next = cfg.knot[cpl_pkg::DEGEN_KNOT][23:0];
      b_next = a_next;
      d_next = cpl_pkg::SEG_W'(1);
      t_next = '0;
    end else if (x1 <= x0) begin
      b_next = a_next;
      d_next = cpl_pkg::SEG_W'(1);
      t_next = '0;
    end
  end

  logic [2:0][7:0]             a0, b0;
  logic [cpl_pkg::SEG_W-1:0]   d0, t0;

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      a0     <= a_next;
      b0     <= b_next;
      d0     <= d_next;
      t0     <= t_next;
      clp[0] <= tag_in.clamped;
    end
  end

  // stage 1: weighted sum with half-up rounding term
  logic [2:0][cpl_pkg::CNUM_W-1:0] cn;
  logic [cpl_pkg::SEG_W-1:0]       d1;

  always_ff @(posedge clk) begin
    if (rdy[1]) begin
      for (int c = 0; c < 3; c++) begin
        cn[c] <= cpl_pkg::CNUM_W'(a0[c]) * cpl_pkg::CNUM_W'(d0 - t0)
               + cpl_pkg::CNUM_W'(b0[c]) * cpl_pkg::CNUM_W'(t0)
               + cpl_pkg::CNUM_W'(d0 >> 1);
      end
      d1     <= d0;
      clp[1] <= clp[0];
    end
  end

  // stages 2..: one quotient bit per stage for all three channels
  logic [ND-1:0][2:0][cpl_pkg::CNUM_W-1:0] rem;
  logic [ND-1:0][2:0][7:0]                 quo;
  logic [ND-1:0][cpl_pkg::SEG_W-1:0]       dv;

  for (genvar j = 0; j < ND; j++) begin : g_div
    logic [2:0][cpl_pkg::CNUM_W-1:0] src_rem;
    logic [2:0][7:0]                 src_quo;
    logic [cpl_pkg::SEG_W-1:0]       src_d;
    logic [cpl_pkg::CNUM_W-1:0]      sh;

    if (j == 0) begin : g_first
      assign src_rem = cn;
      assign src_quo = '0;
      assign src_d   = d1;
    end else begin : g_rest
      assign src_rem = rem[j-1];
      assign src_quo = quo[j-1];
      assign src_d   = dv[j-1];
    end

    assign sh = cpl_pkg::CNUM_W'(src_d) << (ND - 1 - j);

    always_ff @(posedge clk) begin
      if (rdy[2+j]) begin
        for (int c = 0; c < 3; c++) begin
          if (src_rem[c] >= sh) begin
            rem[j][c] <= src_rem[c] - sh;
            quo[j][c] <= src_quo[c] | (8'd1 << (ND - 1 - j));
          end else begin
            rem[j][c] <= src_rem[c];
            quo[j][c] <= src_quo[c];
          end
        end
        dv[j]    <= src_d;
        clp[2+j] <= clp[1+j];
      end
    end
  end

  assign in_stall  = ~rdy[0];
  assign out_valid = v[N-1];
  assign red       = quo[ND-1][2];
  assign green     = quo[ND-1][1];
  assign blue      = quo[ND-1][0];
  assign clamped   = clp[N-1];

endmodule

// ===== design/colormap_piecewise_linear.sv =====
`timescale 1ns / 1ps
// channel   words                       handshake
// in        sample                      in_valid / in_stall
// out       red, green, blue, clamped   out_valid / out_stall
// config    apb register writes         psel, penable, pwrite, pready = 1
//
// one word per clock while out_stall is low; each word passes the front stages,
// the bit-per-stage position divider and the bit-per-stage channel dividers
// rst clears all stage valid bits and loads register reset values
// each stage holds only while its successor is full and stalled, so
// bubbles close up and input is taken while a result waits at the output
module colormap_piecewise_linear (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [cpl_pkg::ADDR_W-1:0]  paddr,
  input  logic [cpl_pkg::BUS_W-1:0]   pwdata,
  output logic [cpl_pkg::BUS_W-1:0]   prdata,
  output logic                        pready,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic signed [31:0]          sample,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  red,
  output logic [7:0]                  green,
  output logic [7:0]                  blue,
  output logic                        clamped
);

  cpl_pkg::cfg_t cfg;

  assign pready = 1'b1;

  cpl_regs u_regs (
    .clk, .rst, .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .cfg
  );

  // front stage 0: clamp and offset
  logic signed [33:0] lo, hi, sv, val, span;
  logic               clp_next;

  always_comb begin
    lo       = 34'(signed'(cfg.range_low));
    hi       = 34'(signed'(cfg.range_high));
    sv       = 34'(sample);
    val      = sv;
    clp_next = 1'b0;
    if (val > hi) begin
      val      = hi - 34'sd1;
      clp_next = 1'b1;
    end
    if (val < lo) begin
      val      = lo + 34'sd1;
      clp_next = 1'b1;
    end
    span = hi - lo;
  end

  logic                         v0, v1, rdy0, rdy1, div_stall;
  logic [cpl_pkg::OFF_W-1:0]    off0;
  cpl_pkg::tag_t                tag0, tag1;
  logic [cpl_pkg::NUM_W-1:0]    num1;
  logic [cpl_pkg::OFF_W:0]      offd;

  assign offd = 34'(val - lo);
  assign rdy1 = ~v1 | ~div_stall;
  assign rdy0 = ~v0 | rdy1;
  assign in_stall = ~rdy0;

  always_ff @(posedge clk) begin
    if (rst) begin
      v0 <= 1'b0;
      v1 <= 1'b0;
    end else begin
      if (rdy0) v0 <= in_valid;
      if (rdy1) v1 <= v0;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy0) begin
      off0         <= offd[cpl_pkg::OFF_W-1:0];
      tag0.clamped <= clp_next;
      tag0.degen   <= (span <= 34'sd0);
    end
    // front stage 1: scale by the step count and fraction
    if (rdy1) begin
      num1 <= (cpl_pkg::NUM_W'(off0) * cpl_pkg::NUM_W'(cpl_pkg::POS_STEPS))
              << cpl_pkg::FRAC_BITS;
      tag1 <= tag0;
    end
  end

  logic                         pv, pstall;
  logic [cpl_pkg::POS_W-1:0]    pos;
  cpl_pkg::tag_t                ptag;

  cpl_pos_div u_pos_div (
    .clk, .rst,
    .in_valid  (v1),
    .in_stall  (div_stall),
    .num       (num1),
    .tag_in    (tag1),
    .divisor   (span[cpl_pkg::SPAN_W-1:0]),
    .out_valid (pv),
    .out_stall (pstall),
    .pos       (pos),
    .tag_out   (ptag)
  );

  cpl_interp u_interp (
    .clk, .rst,
    .in_valid  (pv),
    .in_stall  (pstall),
    .pos       (pos),
    .tag_in    (ptag),
    .cfg       (cfg),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .red, .green, .blue, .clamped
  );

endmodule

// ===== dv/tb_colormap_piecewise_linear.sv =====
`timescale 1ns / 1ps
module tb_colormap_piecewise_linear;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       clamped;
  } color_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
  logic [cpl_pkg::ADDR_W-1:0] paddr = '0;
  logic [cpl_pkg::BUS_W-1:0] pwdata = '0;
  logic [cpl_pkg::BUS_W-1:0] prdata;
  logic pready;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_held = 1'b0;   // word offered and not taken at the last edge
  logic signed [31:0] sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [7:0] red, green, blue;
  logic clamped;

  colormap_piecewise_linear u_dut (
    .clk(clk), .rst(rst), .psel(psel), .penable(penable), .pwrite(pwrite),
    .paddr(paddr), .pwdata(pwdata), .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_stall(in_stall), .sample(sample),
    .out_valid(out_valid), .out_stall(out_stall), .red(red), .green(green),
    .blue(blue), .clamped(clamped)
  );

  // local copy of the register file
  logic [31:0] lo_reg, hi_reg;
  logic [cpl_pkg::KNOT_W-1:0] knot_reg [cpl_pkg::KNOT_REGS];

  logic signed [31:0] sample_q[$];
  color_t color_q[$];
  int errors = 0;
  int mismatches = 0;
  bit calm = 1'b0;      // no idling on either side
  bit hold_off = 1'b0;  // long receiver stall

  initial forever #5 clk = ~clk;

  function automatic color_t map_color(logic signed [31:0] s);
    color_t c;
    longint lo, hi, v, span, pos, x0, x1, d, t, a, b;
    int seg;
    lo = $signed(lo_reg);
    hi = $signed(hi_reg);
    v = s;
    c.clamped = 1'b0;
    if (v > hi) begin v = hi - 1; c.clamped = 1'b1; end
    if (v < lo) begin v = lo + 1; c.clamped = 1'b1; end
    span = hi - lo;
    if (span <= 0) begin
      {c.red, c.green, c.blue} = knot_reg[cpl_pkg::DEGEN_KNOT][23:0];
      return c;
    end
    pos = ((v - lo) * cpl_pkg::POS_STEPS * (64'sd1 <<< cpl_pkg::FRAC_BITS)) / span;
    seg = 0;
    for (int k = 0; k <= cpl_pkg::KNOTS_USED - 2; k++)
      if ((longint'(knot_reg[k][33:24]) <<< cpl_pkg::FRAC_BITS) <= pos) seg = k;
    x0 = knot_reg[seg][33:24];
    x1 = knot_reg[seg+1][33:24];
    d = (x1 - x0) <<< cpl_pkg::FRAC_BITS;
    if (d <= 0) begin
      {c.red, c.green, c.blue} = knot_reg[seg][23:0];
      return c;
    end
    t = pos - (x0 <<< cpl_pkg::FRAC_BITS);
    if (t < 0) t = 0;
    if (t > d) t = d;
    for (int ch = 0; ch < 3; ch++) begin
      a = (knot_reg[seg] >> (16 - 8 * ch)) & 8'hff;
      b = (knot_reg[seg+1] >> (16 - 8 * ch)) & 8'hff;
      a = (a * (d - t) + b * t + d / 2) / d;
      case (ch)
        0: c.red = a[7:0];
        1: c.green = a[7:0];
        default: c.blue = a[7:0];
      endcase
    end
    return c;
  endfunction

  task automatic write_reg(logic [2:0] idx, logic [cpl_pkg::BUS_W-1:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; penable <= 1'b0;
    paddr <= cpl_pkg::ADDR_W'(idx) << 3; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      cpl_pkg::REG_RANGE_LOW: lo_reg = val[31:0];
      cpl_pkg::REG_RANGE_HIGH: hi_reg = val[31:0];
      default: knot_reg[idx - cpl_pkg::REG_KNOT_ZERO] = val[cpl_pkg::KNOT_W-1:0];
    endcase
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || color_q.size() != 0) @(posedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic signed [31:0] rand_sample();
    longint l, h;
    l = $signed(lo_reg);
    h = $signed(hi_reg);
    case ($urandom_range(0, 9))
      0: return $urandom();
      1: return lo_reg + $urandom_range(0, 2) - 1;
      2: return hi_reg + $urandom_range(0, 2) - 1;
      default:
        if (h > l) return 32'(l + longint'($urandom()) % (h - l + 1));
        else return $urandom();
    endcase
  endfunction

  function automatic logic [cpl_pkg::KNOT_W-1:0] rand_knot(int p);
    logic [cpl_pkg::KNOT_W-1:0] k;
    k[33:24] = 10'(p);
    k[23:0] = 24'($urandom());
    return k;
  endfunction

  // driver
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_held) begin
      if (sample_q.size() != 0 && (calm || $urandom_range(0, 99) >= 9)) begin
        in_valid <= 1'b1;
        sample <= sample_q[0];
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    in_held <= !rst && in_valid && in_stall;
    if (!rst && in_valid && !in_stall) begin
      color_q.push_back(map_color(sample_q[0]));
      void'(sample_q.pop_front());
    end
  end

  always @(negedge clk)
    out_stall <= hold_off || (!calm && $urandom_range(0, 99) < 9);

  // monitor
  always @(posedge clk) begin
    color_t got, want;
    if (!rst && out_valid && !out_stall) begin
      got = '{red, green, blue, clamped};
      if (color_q.size() == 0) begin
        errors++;
        $display("unexpected word %h", got);
      end else begin
        want = color_q.pop_front();
        if (got !== want) begin
          errors++;
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: expected r%h g%h b%h c%b, got r%h g%h b%h c%b",
                     want.red, want.green, want.blue, want.clamped,
                     got.red, got.green, got.blue, got.clamped);
        end
      end
    end
  end

  initial begin
    #50_000_000;
    $display("** colormap_piecewise_linear: FAILED **");
    $finish;
  end

  initial begin
    int p1, p2, p3;
    lo_reg = cpl_pkg::RANGE_LOW_RESET;
    hi_reg = cpl_pkg::RANGE_HIGH_RESET;
    for (int k = 0; k < cpl_pkg::KNOT_REGS; k++) knot_reg[k] = cpl_pkg::KNOT_RESET[k];
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed on reset settings
    foreach (knot_reg[k]) sample_q.push_back(32'(knot_reg[k][33:24] * 164));
    sample_q.push_back(32'h8000_0000);
    sample_q.push_back(32'h7fff_ffff);
    sample_q.push_back(32'd0);
    sample_q.push_back(32'd65536);
    sample_q.push_back(-32'sd1);
    sample_q.push_back(32'd65537);
    sample_q.push_back(32'hffff_ffff);
    sample_q.push_back(32'h5555_5555);
    sample_q.push_back(32'haaaa_aaaa);
    drain();

    // degenerate range, zero width segment, extremes
    write_reg(cpl_pkg::REG_RANGE_LOW, 64'd100);
    write_reg(cpl_pkg::REG_RANGE_HIGH, 64'd100);
    sample_q.push_back(32'd100); sample_q.push_back(32'd5); sample_q.push_back(32'd500);
    drain();
    write_reg(cpl_pkg::REG_RANGE_LOW, 64'h8000_0000);
    write_reg(cpl_pkg::REG_RANGE_HIGH, 64'h7fff_ffff);
    write_reg(cpl_pkg::REG_KNOT_ONE, {30'd0, 10'd0, 24'hffffff} & 64'h3_ffff_ffff);
    write_reg(cpl_pkg::REG_KNOT_TWO, 64'h3_ffff_ffff);
    sample_q.push_back(32'h8000_0000); sample_q.push_back(32'h7fff_ffff);
    sample_q.push_back(32'd0); sample_q.push_back(32'h4000_0000);
    drain();

    // random phases with random knot layouts
    for (int ph = 0; ph < 12; ph++) begin
      if (ph % 4 == 3) begin
        write_reg(cpl_pkg::REG_RANGE_LOW, $urandom());
        write_reg(cpl_pkg::REG_RANGE_HIGH, $urandom());
      end else begin
        p1 = int'($urandom_range(0, 65536 * 16)) - 65536 * 8;
        write_reg(cpl_pkg::REG_RANGE_LOW, 64'(32'(p1)));
        write_reg(cpl_pkg::REG_RANGE_HIGH, 64'(32'(p1 + $urandom_range(1, 65536 * 16))));
      end
      p1 = $urandom_range(0, cpl_pkg::POS_STEPS);
      p2 = $urandom_range(p1, cpl_pkg::POS_STEPS);
      p3 = $urandom_range(p2, cpl_pkg::POS_STEPS);
      if (ph % 5 == 4) p2 = p1;
      write_reg(cpl_pkg::REG_KNOT_ZERO,
                rand_knot(ph % 3 == 0 ? 0 : $urandom_range(0, 40)));
      write_reg(cpl_pkg::REG_KNOT_ONE, rand_knot(p1));
      write_reg(cpl_pkg::REG_KNOT_TWO, rand_knot(p2));
      write_reg(cpl_pkg::REG_KNOT_THREE, rand_knot(p3));
      write_reg(cpl_pkg::REG_KNOT_FOUR,
                rand_knot(ph % 6 == 5 ? $urandom_range(0, 1023) : cpl_pkg::POS_STEPS));
      calm = (ph == 2);
      for (int i = 0; i < 150; i++) sample_q.push_back(rand_sample());
      if (ph == 5) begin
        hold_off = 1'b1;
        repeat (200) @(posedge clk);
        hold_off = 1'b0;
      end
      drain();
    end
    calm = 1'b0;

    if (errors == 0 && color_q.size() == 0)
      $display("** colormap_piecewise_linear: PASSED **");
    else
      $display("** colormap_piecewise_linear: FAILED **");
    $finish;
  end
endmodule

// ===== files.f =====
design/cpl_pkg.sv
design/cpl_regs.sv
design/cpl_pos_div.sv
design/cpl_interp.sv
design/colormap_piecewise_linear.sv
dv/tb_colormap_piecewise_linear.sv
